[rtl/core/atd_pkg.sv]
package atd_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GRAVITY_TAU_MS_DEF = 150;

    localparam int TIME_W     = 32;
    localparam int GRAV_W     = 24;
    localparam int MAG_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int MS_W       = 12;
    localparam int SENS_W     = 4;
    localparam int KIND_W     = 2;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_DATA_W = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SENS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DMIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK    = 3'd4;

    localparam logic [SENS_W-1:0] SENS_RST    = 4'd5;
    localparam logic [MS_W-1:0]   IMPULSE_RST = 12'd60;
    localparam logic [MS_W-1:0]   DMIN_RST    = 12'd80;
    localparam logic [MS_W-1:0]   DWIN_RST    = 12'd400;
    localparam logic [MS_W-1:0]   LOCK_RST    = 12'd500;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       sq_load;
        logic       sq_first;
        logic [1:0] sq_axis;
        logic       root_init;
        logic       root_step;
        logic       mag_load;
        logic       dev_load;
        logic       mul_load;
        logic       div_step;
        logic       upd;
        logic       peak_rd;
    } atd_cmd_t;

    // two quotient bits per divider step over the widened numerator
    function automatic int div_steps(int tau);
        int num_w;
        num_w = GRAV_W + $clog2(tau + 1) + 1;
        return (num_w + 1) / 2;
    endfunction

    function automatic logic [THR_W-1:0] threshold(logic [SENS_W-1:0] s);
        logic [SENS_W-1:0] c;
        logic [SENS_W-1:0] m;
        if (s < 4'd1) begin
            c = 4'd1;
        end else if (s > 4'd10) begin
            c = 4'd10;
        end else begin
            c = s;
        end
        m = 4'd11 - c;
        return {m, 9'b0};
    endfunction

endpackage

[rtl/core/atd_dp.sv]
module atd_dp
    import atd_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GRAVITY_TAU_MS = GRAVITY_TAU_MS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  atd_cmd_t                      cmd,
    input  logic [TIME_W-1:0]             in_time,
    input  logic signed [SAMPLE_BITS-1:0] in_x,
    input  logic signed [SAMPLE_BITS-1:0] in_y,
    input  logic signed [SAMPLE_BITS-1:0] in_z,
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic [KIND_W-1:0]             res_kind,
    output logic [MAG_W-1:0]              res_peak
);

    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int RT_W      = SAMPLE_BITS;
    localparam int MX_W      = (RT_W > MAG_W) ? RT_W : MAG_W;
    localparam int DT_W      = $clog2(GRAVITY_TAU_MS + 1);
    localparam int DIV_STEPS = div_steps(GRAVITY_TAU_MS);
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int PROD_W    = GRAV_W + DT_W;

    localparam logic [DT_W:0]       TAU      = (DT_W + 1)'(GRAVITY_TAU_MS);
    localparam logic [DIV_W-1:0]    TAU_HALF = DIV_W'(GRAVITY_TAU_MS / 2);
    localparam logic [TIME_W-1:0]   TAU_T    = TIME_W'(GRAVITY_TAU_MS);
    localparam logic [MX_W-1:0]     MAG_MAX  = MX_W'(17'h0FFFF);

    // configuration
    logic [SENS_W-1:0] sens_reg;
    logic [MS_W-1:0]   imp_reg, dmin_reg, dwin_reg, lock_ms_reg;

    // captured item
    logic [TIME_W-1:0]             time_reg;
    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg;

    // square, root, divide
    logic [SQ_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]   rn_reg, rn_next;
    logic [RT_W:0]     rr_reg, rr_next;
    logic [RT_W-1:0]   rq_reg, rq_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [GRAV_W-1:0] dev_reg;
    logic              up_reg;
    logic [DIV_W-1:0]  dn_reg, dn_next;
    logic [DT_W-1:0]   dr_reg, dr_next;
    logic [DIV_W-1:0]  dq_reg, dq_next;

    // detector state
    logic              primed_reg, primed_next;
    logic [GRAV_W-1:0] grav_reg, grav_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic              above_reg, above_next;
    logic [TIME_W-1:0] astart_reg, astart_next;
    logic              pend_reg, pend_next;
    logic [TIME_W-1:0] first_reg, first_next;
    logic [TIME_W-1:0] lock_reg, lock_next;
    logic [MAG_W-1:0]  peak_reg, peak_next;
    logic [KIND_W-1:0] kind;

    logic [KIND_W-1:0] res_kind_reg;
    logic [MAG_W-1:0]  res_peak_reg;

    // squarer on the magnitude of the selected axis
    logic signed [SAMPLE_BITS-1:0] sq_op;
    logic [SAMPLE_BITS-1:0]        sq_abs;
    logic [SQ_W-1:0]               sq_val;

    always_comb begin
        unique case (cmd.sq_axis)
            AXIS_X:  sq_op = ax_reg;
            AXIS_Y:  sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
    end

    assign sq_abs   = sq_op[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sq_op) : SAMPLE_BITS'(sq_op);
    assign sq_val   = sq_abs * sq_abs;
    assign sum_next = cmd.sq_first ? sq_val : sum_reg + sq_val;

    // one root bit a step
    logic [RT_W+2:0] rt_rs, rt_trial, rt_diff;
    logic            rt_ge;

    always_comb begin
        rt_rs    = {rr_reg, rn_reg[SQ_W-1 -: 2]};
        rt_trial = {1'b0, rq_reg, 2'b01};
        rt_ge    = rt_rs >= rt_trial;
        rt_diff  = rt_rs - rt_trial;
        rn_next  = rn_reg << 2;
        rr_next  = rt_ge ? rt_diff[RT_W:0] : rt_rs[RT_W:0];
        rq_next  = {rq_reg[RT_W-2:0], rt_ge};
    end

    logic [MX_W-1:0]   root_w;
    logic [MAG_W-1:0]  mag_sat;
    logic [GRAV_W-1:0] mag_fx;

    assign root_w  = MX_W'(rq_reg);
    assign mag_sat = (root_w > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : root_w[MAG_W-1:0];
    assign mag_fx  = {mag_reg, {FRAC_W{1'b0}}};

    // gravity step numerator
    logic [TIME_W-1:0] dt;
    logic [PROD_W-1:0] prod;

    assign dt   = time_reg - last_reg;
    assign prod = dev_reg * dt[DT_W-1:0];

    // restoring division by the filter constant, two bits a step
    logic [DT_W:0] dv_r1, dv_r1s, dv_r2, dv_r2s;
    logic          dv_ge1, dv_ge2;

    always_comb begin
        dv_r1   = {dr_reg, dn_reg[DIV_W-1]};
        dv_ge1  = dv_r1 >= TAU;
        dv_r1s  = dv_ge1 ? dv_r1 - TAU : dv_r1;
        dv_r2   = {dv_r1s[DT_W-1:0], dn_reg[DIV_W-2]};
        dv_ge2  = dv_r2 >= TAU;
        dv_r2s  = dv_ge2 ? dv_r2 - TAU : dv_r2;
        dr_next = dv_r2s[DT_W-1:0];
        dq_next = {dq_reg[DIV_W-3:0], dv_ge1, dv_ge2};
        dn_next = dn_reg << 2;
    end

    // tap decision
    logic [GRAV_W-1:0] thr_fx;
    logic              locked;
    logic [TIME_W-1:0] ab_dur, gap, win;
    logic [GRAV_W-1:0] delta;

    assign thr_fx = GRAV_W'({threshold(sens_reg), {FRAC_W{1'b0}}});
    assign locked = ((time_reg - lock_reg) >> (TIME_W - 1)) != '0;
    assign ab_dur = time_reg - astart_reg;
    assign gap    = astart_reg - first_reg;
    assign delta  = dq_reg[GRAV_W-1:0];

    always_comb begin
        primed_next = primed_reg;
        grav_next   = grav_reg;
        last_next   = last_reg;
        above_next  = above_reg;
        astart_next = astart_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        lock_next   = lock_reg;
        peak_next   = peak_reg;
        kind        = KIND_NONE;
        win         = '0;
        if (cmd.peak_rd) begin
            peak_next = '0;
        end else if (cmd.upd) begin
            if (!primed_reg) begin
                primed_next = 1'b1;
                grav_next   = mag_fx;
                last_next   = time_reg;
            end else begin
                last_next = time_reg;
                if (dt >= TAU_T) begin
                    grav_next = mag_fx;
                end else if (up_reg) begin
                    grav_next = grav_reg + delta;
                end else begin
                    grav_next = grav_reg - delta;
                end
                if (dev_reg[GRAV_W-1:FRAC_W] > peak_reg) begin
                    peak_next = dev_reg[GRAV_W-1:FRAC_W];
                end
                if (!above_reg) begin
                    if (dev_reg >= thr_fx && !locked) begin
                        above_next  = 1'b1;
                        astart_next = time_reg;
                    end
                end else if ({dev_reg, 1'b0} < {1'b0, thr_fx}) begin
                    above_next = 1'b0;
                    if (ab_dur <= TIME_W'(imp_reg)) begin
                        if (pend_reg) begin
                            // ringing outside the double window leaves the first pending
                            if (gap >= TIME_W'(dmin_reg) && gap <= TIME_W'(dwin_reg)) begin
                                pend_next = 1'b0;
                                lock_next = time_reg + TIME_W'(lock_ms_reg);
                                kind      = KIND_DOUBLE;
                            end
                        end else begin
                            pend_next  = 1'b1;
                            first_next = astart_reg;
                        end
                    end else begin
                        pend_next = 1'b0;
                    end
                end else if (ab_dur > TIME_W'(imp_reg)) begin
                    // sustained motion: drop the excursion, half lockout
                    above_next = 1'b0;
                    pend_next  = 1'b0;
                    lock_next  = time_reg + TIME_W'(lock_ms_reg[MS_W-1:1]);
                end
                win = time_reg - first_next;
                if (pend_next && !above_next && win > TIME_W'(dwin_reg)) begin
                    pend_next = 1'b0;
                    lock_next = time_reg + TIME_W'(lock_ms_reg);
                    kind      = KIND_SINGLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg    <= SENS_RST;
            imp_reg     <= IMPULSE_RST;
            dmin_reg    <= DMIN_RST;
            dwin_reg    <= DWIN_RST;
            lock_ms_reg <= LOCK_RST;
            primed_reg  <= 1'b0;
            above_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            lock_reg    <= '0;
            peak_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SENS:    sens_reg    <= cfg_data[SENS_W-1:0];
                    CFG_IMPULSE: imp_reg     <= cfg_data;
                    CFG_DMIN:    dmin_reg    <= cfg_data;
                    CFG_DWIN:    dwin_reg    <= cfg_data;
                    CFG_LOCK:    lock_ms_reg <= cfg_data;
                    default: ;
                endcase
            end
            primed_reg <= primed_next;
            above_reg  <= above_next;
            pend_reg   <= pend_next;
            lock_reg   <= lock_next;
            peak_reg   <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            time_reg <= in_time;
            ax_reg   <= in_x;
            ay_reg   <= in_y;
            az_reg   <= in_z;
        end
        if (cmd.sq_load) begin
            sum_reg <= sum_next;
        end
        if (cmd.root_init) begin
            rn_reg <= sum_reg;
            rr_reg <= '0;
            rq_reg <= '0;
        end else if (cmd.root_step) begin
            rn_reg <= rn_next;
            rr_reg <= rr_next;
            rq_reg <= rq_next;
        end
        if (cmd.mag_load) begin
            mag_reg <= mag_sat;
        end
        if (cmd.dev_load) begin
            up_reg  <= mag_fx >= grav_reg;
            dev_reg <= (mag_fx >= grav_reg) ? mag_fx - grav_reg : grav_reg - mag_fx;
        end
        if (cmd.mul_load) begin
            dn_reg <= DIV_W'(prod) + TAU_HALF;
            dr_reg <= '0;
            dq_reg <= '0;
        end else if (cmd.div_step) begin
            dn_reg <= dn_next;
            dr_reg <= dr_next;
            dq_reg <= dq_next;
        end
        grav_reg   <= grav_next;
        last_reg   <= last_next;
        astart_reg <= astart_next;
        first_reg  <= first_next;
        if (cmd.peak_rd) begin
            res_kind_reg <= KIND_NONE;
            res_peak_reg <= peak_reg;
        end else if (cmd.upd) begin
            res_kind_reg <= kind;
            res_peak_reg <= '0;
        end
    end

    assign res_kind = res_kind_reg;
    assign res_peak = res_peak_reg;

endmodule

[rtl/core/atd_ctrl.sv]
module atd_ctrl
    import atd_pkg::*;
#(
    parameter int ROOT_STEPS = SAMPLE_BITS_DEF,
    parameter int DIV_STEPS  = div_steps(GRAVITY_TAU_MS_DEF)
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_req,
    output logic     m_tvalid,
    input  logic     m_tready,
    output atd_cmd_t cmd
);

    localparam int MAX_STEPS = (ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PEAK  = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_SQZ   = 4'd4;
    localparam logic [3:0] S_RINIT = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_DEV   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_UPD   = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mv_reg, mv_next;
    logic             out_free;
    logic             res_load;

    assign out_free = !mv_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = s_req ? S_PEAK : S_SQX;
                end
            end
            S_PEAK: begin
                if (out_free) begin
                    cmd.peak_rd = 1'b1;
                    res_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SQX: begin
                cmd.sq_load  = 1'b1;
                cmd.sq_first = 1'b1;
                cmd.sq_axis  = AXIS_X;
                state_next   = S_SQY;
            end
            S_SQY: begin
                cmd.sq_load = 1'b1;
                cmd.sq_axis = AXIS_Y;
                state_next  = S_SQZ;
            end
            S_SQZ: begin
                cmd.sq_load = 1'b1;
                cmd.sq_axis = AXIS_Z;
                state_next  = S_RINIT;
            end
            S_RINIT: begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                cmd.mag_load = 1'b1;
                state_next   = S_DEV;
            end
            S_DEV: begin
                cmd.dev_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL: begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.upd    = 1'b1;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (res_load) begin
            mv_next = 1'b1;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end else begin
            mv_next = mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;

endmodule

[rtl/core/accel_tap_detector_core.sv]
// Tap detector for timestamped three-axis accelerometer samples. One item at a
// time: a sample (s_tuser 0) runs through the squarer, the one-bit-a-step square
// root and the two-bit-a-step divider that scales the gravity step by
// GRAVITY_TAU_MS before the next item can be taken. A peak read (s_tuser 1)
// returns and clears the peak. Every item gives exactly one result; results
// wait in an output register, and an item that finishes while the previous
// result is still held stalls until it is taken. Configuration writes are
// always accepted and must only be issued while idle.
module accel_tap_detector_core
    import atd_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GRAVITY_TAU_MS = GRAVITY_TAU_MS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // time_ms, accel_x, accel_y, accel_z, zero padding
    input  logic [((TIME_W + 3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tap_kind, peak_value, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIV_STEPS = div_steps(GRAVITY_TAU_MS);
    localparam int X_LO      = TIME_W;
    localparam int Y_LO      = TIME_W + SAMPLE_BITS;
    localparam int Z_LO      = TIME_W + 2 * SAMPLE_BITS;

    atd_cmd_t          cmd;
    logic [KIND_W-1:0] res_kind;
    logic [MAG_W-1:0]  res_peak;

    atd_ctrl #(
        .ROOT_STEPS (SAMPLE_BITS),
        .DIV_STEPS  (DIV_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    atd_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GRAVITY_TAU_MS (GRAVITY_TAU_MS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_time   (s_tdata[TIME_W-1:0]),
        .in_x      (s_tdata[X_LO +: SAMPLE_BITS]),
        .in_y      (s_tdata[Y_LO +: SAMPLE_BITS]),
        .in_z      (s_tdata[Z_LO +: SAMPLE_BITS]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_kind  (res_kind),
        .res_peak  (res_peak)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_DATA_W'({res_peak, res_kind});

endmodule

[bench/tb_accel_tap_detector_core.sv]
`timescale 1ns / 100ps

module tb_accel_tap_detector_core;
    import atd_pkg::*;

    localparam int SDATA_W = ((TIME_W + 3 * SAMPLE_BITS_DEF + 7) / 8) * 8;

    typedef struct {
        logic                    peak_read;
        logic [TIME_W-1:0]       stamp;
        logic signed [15:0]      ax;
        logic signed [15:0]      ay;
        logic signed [15:0]      az;
    } tap_req_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [MAG_W-1:0]  peak;
    } tap_res_t;

    typedef enum {TAP_SHORT, TAP_MOTION, TAP_LONG} tap_shape_e;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SDATA_W-1:0]    s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // detector copy: configuration
    logic [SENS_W-1:0] sens_reg;
    logic [MS_W-1:0]   imp_reg;
    logic [MS_W-1:0]   dmin_reg;
    logic [MS_W-1:0]   dwin_reg;
    logic [MS_W-1:0]   lock_reg;

    // detector copy: state
    logic              primed;
    logic [GRAV_W-1:0] grav_est;
    logic [TIME_W-1:0] last_ms;
    logic              above;
    logic [TIME_W-1:0] above_ms;
    logic              pending;
    logic [TIME_W-1:0] first_tap_ms;
    logic [TIME_W-1:0] lock_end;
    logic [MAG_W-1:0]  peak_dev;

    tap_req_t    sample_q[$];
    tap_res_t    tap_result_q[$];
    tap_req_t    drv_item;
    tap_res_t    due;
    int          in_flight  = 0;
    int          queued     = 0;
    int          mismatches = 0;
    int          burst_left = 1;
    int          gap_left   = 0;
    int          rx_cycle   = 0;
    int          hold_left  = 0;
    logic [31:0] now_ms     = '0;

    accel_tap_detector_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("** accel_tap_detector_core: FAILED **");
        $finish;
    end

    function automatic void reset_model();
        sens_reg     = SENS_RST;
        imp_reg      = IMPULSE_RST;
        dmin_reg     = DMIN_RST;
        dwin_reg     = DWIN_RST;
        lock_reg     = LOCK_RST;
        primed       = 1'b0;
        grav_est     = '0;
        last_ms      = '0;
        above        = 1'b0;
        above_ms     = '0;
        pending      = 1'b0;
        first_tap_ms = '0;
        lock_end     = '0;
        peak_dev     = '0;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SENS:    sens_reg = val[SENS_W-1:0];
            CFG_IMPULSE: imp_reg  = val[MS_W-1:0];
            CFG_DMIN:    dmin_reg = val[MS_W-1:0];
            CFG_DWIN:    dwin_reg = val[MS_W-1:0];
            CFG_LOCK:    lock_reg = val[MS_W-1:0];
            default:     ;
        endcase
    endfunction

    function automatic int thr_lsb();
        int s;
        s = sens_reg;
        if (s < 1) s = 1;
        if (s > 10) s = 10;
        return (11 - s) * 512;
    endfunction

    // build the root one bit at a time from the top
    function automatic logic [MAG_W-1:0] root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) r = c;
        end
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic tap_res_t detect_tap(tap_req_t r);
        tap_res_t    res;
        longint      sx;
        longint      sy;
        longint      sz;
        logic [31:0] mag_fx;
        logic [31:0] dt;
        logic [31:0] dev;
        logic [31:0] grav_step;
        logic [31:0] thr_fx;
        logic [31:0] dur;
        logic [31:0] gap;
        logic [31:0] since_lock;
        logic        rising;
        res.kind = KIND_NONE;
        res.peak = '0;
        if (r.peak_read) begin
            res.peak = peak_dev;
            peak_dev = '0;
            return res;
        end
        sx = r.ax;
        sy = r.ay;
        sz = r.az;
        mag_fx = {8'd0, root_floor(sx * sx + sy * sy + sz * sz), 8'd0};
        if (!primed) begin
            primed   = 1'b1;
            grav_est = mag_fx[GRAV_W-1:0];
            last_ms  = r.stamp;
            return res;
        end
        dt      = r.stamp - last_ms;
        last_ms = r.stamp;
        rising  = mag_fx >= {8'd0, grav_est};
        dev     = rising ? mag_fx - grav_est : grav_est - mag_fx;
        if (dt >= GRAVITY_TAU_MS_DEF) begin
            grav_est = mag_fx[GRAV_W-1:0];
        end else begin
            grav_step = 32'((64'(dev) * dt + GRAVITY_TAU_MS_DEF / 2) / GRAVITY_TAU_MS_DEF);
            grav_est  = rising ? grav_est + grav_step[23:0] : grav_est - grav_step[23:0];
        end
        if (dev[31:8] > peak_dev) peak_dev = dev[23:8];

        thr_fx     = 32'(thr_lsb()) << 8;
        since_lock = r.stamp - lock_end;
        dur        = r.stamp - above_ms;
        if (!above) begin
            if (dev >= thr_fx && !since_lock[31]) begin
                above    = 1'b1;
                above_ms = r.stamp;
            end
        end else if ({dev, 1'b0} < {1'b0, thr_fx}) begin
            above = 1'b0;
            if (dur <= imp_reg) begin
                if (pending) begin
                    gap = above_ms - first_tap_ms;
                    if (gap >= dmin_reg && gap <= dwin_reg) begin
                        pending  = 1'b0;
                        lock_end = r.stamp + lock_reg;
                        res.kind = KIND_DOUBLE;
                    end
                end else begin
                    pending      = 1'b1;
                    first_tap_ms = above_ms;
                end
            end else begin
                pending = 1'b0;
            end
        end else if (dur > imp_reg) begin
            // still moving: drop the excursion and hold off for half the lockout
            above    = 1'b0;
            pending  = 1'b0;
            lock_end = r.stamp + (lock_reg >> 1);
        end

        dur = r.stamp - first_tap_ms;
        if (pending && !above && dur > dwin_reg) begin
            pending  = 1'b0;
            lock_end = r.stamp + lock_reg;
            res.kind = KIND_SINGLE;
        end
        return res;
    endfunction

    function automatic void push_req(logic rd, logic [31:0] stamp,
                                     logic [15:0] x, logic [15:0] y, logic [15:0] z);
        tap_req_t r;
        r.peak_read = rd;
        r.stamp     = stamp;
        r.ax        = x;
        r.ay        = y;
        r.az        = z;
        sample_q.push_back(r);
        in_flight++;
        queued++;
    endfunction

    // roughly 1 g along a random axis with a little noise
    function automatic void queue_rest(logic [31:0] dt);
        logic [15:0] v [3];
        int          g;
        g = $urandom_range(0, 2);
        foreach (v[i]) v[i] = $urandom_range(0, 160) - 80;
        v[g] = 2048 + $urandom_range(0, 160) - 80;
        if ($urandom_range(0, 1) == 1) v[g] = -v[g];
        now_ms += dt;
        push_req(1'b0, now_ms, v[0], v[1], v[2]);
    endfunction

    function automatic void queue_spike(logic [31:0] dt);
        logic [15:0] v [3];
        int          g;
        g = $urandom_range(0, 2);
        foreach (v[i]) v[i] = $urandom_range(0, 160) - 80;
        v[g] = 2048 + thr_lsb() + $urandom_range(256, 3000);
        if ($urandom_range(0, 1) == 1) v[g] = -v[g];
        now_ms += dt;
        push_req(1'b0, now_ms, v[0], v[1], v[2]);
    endfunction

    // one excursion; returns the time it arms
    function automatic logic [31:0] make_tap(tap_shape_e shape, logic [31:0] lead, int extra_max);
        int          extra;
        logic [31:0] span;
        logic [31:0] start;
        logic [31:0] held;
        extra = $urandom_range(0, extra_max);
        span  = imp_reg / (extra + 1);
        if (span > 8) span = 8;
        queue_spike(lead);
        start = now_ms;
        repeat (extra) queue_spike($urandom_range(0, span));
        held = now_ms - start;
        case (shape)
            TAP_SHORT: queue_rest($urandom_range(0, span));
            TAP_MOTION: begin
                queue_spike(imp_reg - held + 1 + $urandom_range(0, 20));
                queue_rest($urandom_range(1, 30));
            end
            default: queue_rest(imp_reg - held + 1 + $urandom_range(0, 20));
        endcase
        return start;
    endfunction

    function automatic void tap_pair(logic [31:0] gap, logic [31:0] lead);
        logic [31:0] first;
        logic [31:0] left;
        first = make_tap(TAP_SHORT, lead, 2);
        left  = first + gap - now_ms;
        if (!left[31] && left > 2) begin
            queue_rest(left / 2);
            left = first + gap - now_ms;
        end
        void'(make_tap(($urandom_range(0, 3) == 0) ? TAP_MOTION : TAP_SHORT,
                       left[31] ? 32'd0 : left, 2));
    endfunction

    task automatic wait_idle();
        while (in_flight != 0 || tap_result_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_config(input int sens, input int imp, input int dmin,
                              input int dwin, input int lock);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{CFG_SENS, CFG_IMPULSE, CFG_DMIN, CFG_DWIN, CFG_LOCK};
        val = '{CFG_DATA_W'(sens), CFG_DATA_W'(imp), CFG_DATA_W'(dmin),
                CFG_DATA_W'(dwin), CFG_DATA_W'(lock)};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            store_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        push_req(1'b1, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        // prime and hit the extremes while the reset lockout still covers bit 31
        now_ms = 32'h8000_0000;
        push_req(1'b0, now_ms, 16'h8000, 16'h8000, 16'h8000);
        now_ms += 1;
        push_req(1'b0, now_ms, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        now_ms += 1;
        push_req(1'b0, now_ms, 16'h0000, 16'h0000, 16'h0000);
        push_req(1'b1, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
        push_req(1'b1, 32'h7FFF_FFFF, 16'hFFFF, 16'h0001, 16'h8000);
        // wrap the timestamp through zero
        now_ms = 32'hFFFF_FFF0;
        queue_rest(0);
        queue_rest(32'h20);
        void'(make_tap(TAP_SHORT, 10, 0));
        queue_rest(450);
        tap_pair(150, 600);
        // ringing: second impulse too soon, first one stays pending
        tap_pair(40, 600);
        queue_rest(450);
        void'(make_tap(TAP_MOTION, 600, 0));
        void'(make_tap(TAP_LONG, 300, 0));
    endtask

    task automatic run_phase(int budget);
        logic [31:0] gap;
        queued = 0;
        if ($urandom_range(0, 1) == 1) now_ms = $urandom();
        while (queued < budget) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(0, 2)) queue_rest($urandom_range(1, 40));
                    void'(make_tap(TAP_SHORT, $urandom_range(1, 40), 2));
                    repeat ($urandom_range(0, 2)) queue_rest($urandom_range(1, 40));
                    queue_rest(dwin_reg + $urandom_range(1, 60));
                    if ($urandom_range(0, 1) == 1) queue_rest(lock_reg + $urandom_range(1, 60));
                end
                2, 3, 4: begin
                    if (dmin_reg <= dwin_reg && $urandom_range(0, 3) != 0) begin
                        gap = $urandom_range(dmin_reg, dwin_reg);
                    end else begin
                        gap = $urandom_range(0, dwin_reg + 200);
                    end
                    tap_pair(gap, $urandom_range(1, 40));
                    queue_rest(dwin_reg + $urandom_range(1, 60));
                    if ($urandom_range(0, 1) == 1) queue_rest(lock_reg + $urandom_range(1, 60));
                end
                5: begin
                    void'(make_tap(($urandom_range(0, 1) == 1) ? TAP_MOTION : TAP_LONG,
                                   $urandom_range(1, 40), 2));
                    queue_rest($urandom_range(1, 200));
                end
                6: begin
                    repeat ($urandom_range(1, 2))
                        push_req(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
                end
                7: begin
                    repeat ($urandom_range(1, 4)) begin
                        now_ms = $urandom();
                        push_req($urandom_range(0, 3) == 0, now_ms,
                                 $urandom(), $urandom(), $urandom());
                    end
                end
                8: begin
                    repeat ($urandom_range(1, 5)) queue_rest($urandom_range(0, 200));
                end
                default: begin
                    now_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    queue_rest(0);
                end
            endcase
        end
        wait_idle();
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_items();
        run_phase(100);
        set_config(10, 4095, 0, 4095, 0);
        run_phase(115);
        set_config(1, 0, 4095, 0, 4095);
        run_phase(115);
        set_config(0, 30, 20, 150, 100);
        run_phase(115);
        set_config(15, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
        run_phase(115);
        set_config($urandom_range(11, 14), $urandom_range(10, 120), $urandom_range(0, 100),
                   $urandom_range(100, 600), $urandom_range(0, 800));
        run_phase(115);
        set_config($urandom_range(2, 9), $urandom_range(20, 100), $urandom_range(30, 150),
                   $urandom_range(150, 500), $urandom_range(100, 600));
        run_phase(115);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** accel_tap_detector_core: PASSED **");
        end else begin
            $display("** accel_tap_detector_core: FAILED **");
        end
        $finish;
    end

    // sender: bursts of items with random gaps, some bursts back to back
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tap_result_q.push_back(detect_tap(drv_item));
                in_flight--;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || sample_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    drv_item = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= SDATA_W'({drv_item.az, drv_item.ay, drv_item.ax, drv_item.stamp});
                    s_tuser  <= drv_item.peak_read;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                    end
                end
            end
        end
    end

    // receiver: stall pattern steps through four modes on rx_cycle[9:8], with a long hold now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 7000 == 3000) hold_left = 600;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_cycle[9:8])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
                    2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycle[1] ^ rx_cycle[3];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (tap_result_q.size() == 0) begin
                $error("unexpected item: tap_kind %0d peak_value %0d",
                       m_tdata[KIND_W-1:0], m_tdata[KIND_W+MAG_W-1:KIND_W]);
                mismatches++;
            end else begin
                due = tap_result_q.pop_front();
                if (m_tdata[KIND_W-1:0] !== due.kind) begin
                    $error("tap_kind: expected %0d, got %0d", due.kind, m_tdata[KIND_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[KIND_W+MAG_W-1:KIND_W] !== due.peak) begin
                    $error("peak_value: expected %0d, got %0d", due.peak,
                           m_tdata[KIND_W+MAG_W-1:KIND_W]);
                    mismatches++;
                end
            end
        end
    end

endmodule
